// File: src/tcc_pkg.sv
`default_nettype none
package tcc_pkg;

   localparam int MEM_WORDS_DEF = 65536;

   localparam logic [31:0] SP_RESET      = 32'h0000_7000;
   localparam logic [31:0] PC_RESET      = 32'h0000_0100;
   localparam logic [15:0] PERIOD_RESET  = 16'd1000;
   localparam logic [31:0] KEY_ADDR      = 32'h0000_FFF1;
   localparam logic [31:0] KBD_CTRL_ADDR = 32'h0000_FFF2;

   // Opcodes
   localparam logic [3:0] OP_SYS   = 4'h0;
   localparam logic [3:0] OP_ADD   = 4'h1;
   localparam logic [3:0] OP_SUB   = 4'h2;
   localparam logic [3:0] OP_MUL   = 4'h3;
   localparam logic [3:0] OP_DIV   = 4'h4;
   localparam logic [3:0] OP_MOD   = 4'h5;
   localparam logic [3:0] OP_AND   = 4'h6;
   localparam logic [3:0] OP_OR    = 4'h7;
   localparam logic [3:0] OP_XOR   = 4'h8;
   localparam logic [3:0] OP_MISC  = 4'hA;
   localparam logic [3:0] OP_LOAD  = 4'hC;
   localparam logic [3:0] OP_STORE = 4'hD;
   localparam logic [3:0] OP_ROT   = 4'hE;

   // Sub-operations of the miscellaneous group
   localparam logic [3:0] SUB_NEG   = 4'h0;
   localparam logic [3:0] SUB_NOT   = 4'h1;
   localparam logic [3:0] SUB_MOVE  = 4'h2;
   localparam logic [3:0] SUB_CALL  = 4'h3;
   localparam logic [3:0] SUB_JUMP  = 4'h4;
   localparam logic [3:0] SUB_SR    = 4'h5;
   localparam logic [3:0] SUB_STACK = 4'h6;

   localparam logic [3:0] CALL_CALL = 4'h0;
   localparam logic [3:0] CALL_RET  = 4'h1;
   localparam logic [3:0] CALL_TRAP = 4'h2;

   localparam logic [3:0] JMP_ALWAYS = 4'h0;
   localparam logic [3:0] JMP_ZERO   = 4'h1;
   localparam logic [3:0] JMP_NEG    = 4'h2;
   localparam logic [3:0] JMP_NZERO  = 4'h3;

   localparam logic [3:0] MODE_CLEAR = 4'h0;
   localparam logic [3:0] MODE_SET   = 4'h1;

   localparam logic [3:0] LD_IMM   = 4'h0;
   localparam logic [3:0] LD_ABS   = 4'h1;
   localparam logic [3:0] LD_IND   = 4'h2;
   localparam logic [3:0] LD_BASE  = 4'h3;

   // Operand nibbles
   localparam logic [3:0] N_SP   = 4'h8;
   localparam logic [3:0] N_SR   = 4'h9;
   localparam logic [3:0] N_PC   = 4'hA;
   localparam logic [3:0] N_ONE  = 4'hB;
   localparam logic [3:0] N_ZERO = 4'hC;
   localparam logic [3:0] N_MONE = 4'hD;
   localparam logic [3:0] N_IMM  = 4'hE;
   localparam logic [3:0] N_NONE = 4'hF;

   // Host actions
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;

   // Interrupt codes as reported
   localparam logic [2:0] IRQ_NONE  = 3'd0;
   localparam logic [2:0] IRQ_FAULT = 3'd1;
   localparam logic [2:0] IRQ_KEY   = 3'd2;
   localparam logic [2:0] IRQ_TRAP  = 3'd3;
   localparam logic [2:0] IRQ_TIMER = 3'd4;

   typedef enum logic [16:0] {
      S_IDLE   = 17'h00001,
      S_HOST   = 17'h00002,
      S_HOSTQ  = 17'h00004,
      S_KEY    = 17'h00008,
      S_FETCH  = 17'h00010,
      S_FETCHQ = 17'h00020,
      S_RB     = 17'h00040,
      S_RC     = 17'h00080,
      S_RD     = 17'h00100,
      S_EXEC   = 17'h00200,
      S_DIV    = 17'h00400,
      S_MEM    = 17'h00800,
      S_MEMQ   = 17'h01000,
      S_WB     = 17'h02000,
      S_IRQA   = 17'h04000,
      S_IRQB   = 17'h08000,
      S_DONE   = 17'h10000
   } state_type;

   function automatic logic [31:0] reg_rd(input logic [3:0] n, input logic [31:0] v,
                                          input logic [31:0] sp, input logic [31:0] sr,
                                          input logic [31:0] pc);
      logic [31:0] res;
      case (n)
         N_SP:           res = sp;
         N_SR:           res = sr;
         N_PC:           res = pc;
         N_ONE:          res = 32'd1;
         N_MONE:         res = 32'hFFFF_FFFF;
         N_ZERO, N_IMM,
         N_NONE:         res = 32'd0;
         default:        res = v;
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

// File: src/tcc_div.sv
`default_nettype none
module tcc_div
   import tcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   input  wire logic        is_mod,
   output logic             done,
   output logic [31:0]      result
);

   logic [31:0] q_ff, q_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        qneg_ff, qneg_in;
   logic        rneg_ff, rneg_in;
   logic        mod_ff, mod_in;
   logic [32:0] rem_sh;
   logic [32:0] diff;

   assign rem_sh = {rem_ff, q_ff[31]};
   assign diff   = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      mod_in  = mod_ff;
      if (start) begin
         q_in    = dividend[31] ? (32'd0 - dividend) : dividend;
         dvs_in  = divisor[31] ? (32'd0 - divisor) : divisor;
         rem_in  = 32'd0;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
         qneg_in = dividend[31] ^ divisor[31];
         rneg_in = dividend[31];
         mod_in  = is_mod;
      end else if (busy_ff) begin
         // One quotient bit per cycle, restoring form on magnitudes.
         if (!diff[32]) begin
            rem_in = diff[31:0];
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            q_in   = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
      mod_ff  <= mod_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = mod_ff ? (rneg_ff ? (32'd0 - rem_ff) : rem_ff)
                          : (qneg_ff ? (32'd0 - q_ff) : q_ff);

endmodule
`default_nettype wire

// File: src/teaching_cpu_core_step.sv
`default_nettype none
// Teaching processor core with its own word memory. Each item writes a memory word, reads
// one, or runs one instruction; every item gives exactly one result. All memory traffic
// goes through one single-port synchronous RAM and the eight general registers sit in a
// small register-file RAM read one operand per cycle, so items are handled one at a time.
// A divide or modulo forms its quotient one bit per cycle. The next item is taken while
// a result still waits on the response side. The timer period register may be written at
// any time the core is idle.
module teaching_cpu_core_step
   import tcc_pkg::*;
#(
   parameter int MEM_WORDS = MEM_WORDS_DEF
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_action,
   input  wire logic [15:0]        req_address,
   input  wire logic signed [31:0] req_data,
   input  wire logic               req_key_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_read_data,
   output logic [15:0]             rsp_pc_after,
   output logic                    rsp_halted,
   output logic                    rsp_invalid_instruction,
   output logic                    rsp_constant_write_fault,
   output logic [2:0]              rsp_interrupt_taken,
   output logic [2:0]              rsp_status_bits,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [15:0]        csr_timer_period
);

   localparam int          AW      = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam logic [31:0] MEM_LIM = 32'(MEM_WORDS);
   localparam bit          KEY_OK  = KEY_ADDR < MEM_LIM;
   localparam bit          CTRL_OK = KBD_CTRL_ADDR < MEM_LIM;

   state_type state_ff, state_in;

   logic [1:0]  act_ff, act_in;
   logic [15:0] haddr_ff, haddr_in;
   logic [31:0] hdata_ff, hdata_in;
   logic        key_ff, key_in;
   logic [31:0] ins_ff, ins_in;
   logic [31:0] v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [31:0] r_ff, r_in;
   logic        wb_ff, wb_in;
   logic [31:0] maddr_ff, maddr_in;
   logic [31:0] mdata_ff, mdata_in;
   logic        mwr_ff, mwr_in;
   logic        mret_ff, mret_in;
   logic        inr_ff, inr_in;
   logic [31:0] sp_ff, sp_in, sr_ff, sr_in, pc_ff, pc_in;
   logic [15:0] tc_ff, tc_in;
   logic [15:0] period_ff, period_in;
   logic        fire_ff, fire_in;
   logic [2:0]  pend_ff, pend_in;   // bit 0 fault, bit 1 keyboard, bit 2 trap
   logic        halt_ff, halt_in;
   logic        bad_ff, bad_in, cf_ff, cf_in;
   logic [2:0]  irq_ff, irq_in;
   logic [31:0] rd_ff, rd_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_rd_ff, rsp_rd_in;
   logic [15:0] rsp_pc_ff, rsp_pc_in;
   logic        rsp_halt_ff, rsp_halt_in;
   logic        rsp_bad_ff, rsp_bad_in;
   logic        rsp_cf_ff, rsp_cf_in;
   logic [2:0]  rsp_irq_ff, rsp_irq_in;
   logic [2:0]  rsp_sr_ff, rsp_sr_in;

   // Main memory, single port, read-first
   logic [31:0] mem [MEM_WORDS];
   logic [31:0] mem_q;
   logic        mem_we;
   logic [31:0] mem_a;
   logic [31:0] mem_wd;

   // General register file with per-entry valid bits standing in for the zero reset
   logic [31:0] rf [8];
   logic [31:0] rf_q;
   logic [7:0]  rf_vld_ff;
   logic        rf_qv_ff;
   logic        rf_we;
   logic [2:0]  rf_wa, rf_ra;
   logic [31:0] rf_val;

   logic [3:0]  op, n1, n2, n3;
   logic [31:0] imm, sext;
   logic [31:0] a1, a2, a3, g2, g3;
   logic        n3_const;
   logic [63:0] rot;
   logic [31:0] sp_inc;
   logic [15:0] tc_inc;
   logic        div_start, div_done;
   logic [31:0] div_res;

   assign op       = ins_ff[31:28];
   assign n1       = ins_ff[27:24];
   assign n2       = ins_ff[23:20];
   assign n3       = ins_ff[19:16];
   assign imm      = {16'd0, ins_ff[15:0]};
   assign sext     = {{16{ins_ff[15]}}, ins_ff[15:0]};
   assign g2       = reg_rd(n2, v2_ff, sp_ff, sr_ff, pc_ff);
   assign g3       = reg_rd(n3, v3_ff, sp_ff, sr_ff, pc_ff);
   assign a1       = (n1 == N_IMM) ? sext : reg_rd(n1, v1_ff, sp_ff, sr_ff, pc_ff);
   assign a2       = (n2 == N_IMM) ? sext : g2;
   assign a3       = (n3 == N_IMM) ? sext : g3;
   assign n3_const = n3 > N_PC;
   assign rot      = {a2, a2} << a1[4:0];
   assign sp_inc   = sp_ff + 32'd1;
   assign tc_inc   = tc_ff + 16'd1;
   assign rf_val   = rf_qv_ff ? rf_q : 32'd0;

   tcc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a1),
      .divisor  (a2),
      .is_mod   (op == OP_MOD),
      .done     (div_done),
      .result   (div_res)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_a[AW-1:0]] <= mem_wd;
      end
      mem_q <= mem[mem_a[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf[rf_wa] <= r_ff;
      end
      rf_q <= rf[rf_ra];
   end

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      haddr_in  = haddr_ff;
      hdata_in  = hdata_ff;
      key_in    = key_ff;
      ins_in    = ins_ff;
      v1_in     = v1_ff;
      v2_in     = v2_ff;
      v3_in     = v3_ff;
      r_in      = r_ff;
      wb_in     = wb_ff;
      maddr_in  = maddr_ff;
      mdata_in  = mdata_ff;
      mwr_in    = mwr_ff;
      mret_in   = mret_ff;
      inr_in    = inr_ff;
      sp_in     = sp_ff;
      sr_in     = sr_ff;
      pc_in     = pc_ff;
      tc_in     = tc_ff;
      fire_in   = fire_ff;
      pend_in   = pend_ff;
      halt_in   = halt_ff;
      bad_in    = bad_ff;
      cf_in     = cf_ff;
      irq_in    = irq_ff;
      rd_in     = rd_ff;
      period_in = csr_valid ? csr_timer_period : period_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rd_in    = rsp_rd_ff;
      rsp_pc_in    = rsp_pc_ff;
      rsp_halt_in  = rsp_halt_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_cf_in    = rsp_cf_ff;
      rsp_irq_in   = rsp_irq_ff;
      rsp_sr_in    = rsp_sr_ff;

      mem_we    = 1'b0;
      mem_a     = pc_ff;
      mem_wd    = mdata_ff;
      rf_ra     = n1[2:0];
      rf_we     = 1'b0;
      rf_wa     = n3[2:0];
      div_start = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               haddr_in = req_address;
               hdata_in = req_data;
               key_in   = req_key_ready;
               bad_in   = 1'b0;
               cf_in    = 1'b0;
               irq_in   = IRQ_NONE;
               rd_in    = 32'd0;
               if (req_action == ACT_WRITE || req_action == ACT_READ) begin
                  state_in = S_HOST;
               end else if (halt_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_KEY;
               end
            end
         end
         S_HOST: begin
            mem_a  = {16'd0, haddr_ff};
            mem_wd = hdata_ff;
            inr_in = mem_a < MEM_LIM;
            mem_we = (act_ff == ACT_WRITE) && (mem_a < MEM_LIM);
            state_in = (act_ff == ACT_WRITE) ? S_DONE : S_HOSTQ;
         end
         S_HOSTQ: begin
            rd_in    = inr_ff ? mem_q : 32'd0;
            state_in = S_DONE;
         end
         S_KEY: begin
            if (key_ff && !sr_ff[1]) begin
               pend_in[1] = 1'b1;
            end
            mem_a    = KEY_ADDR;
            mem_wd   = {31'd0, key_ff};
            mem_we   = KEY_OK;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            mem_a = pc_ff;
            if (pc_ff >= MEM_LIM) begin
               // No instruction runs after a fetch fault.
               pend_in[0] = 1'b1;
               pc_in      = pc_ff + 32'd1;
               state_in   = S_IRQA;
            end else begin
               state_in = S_FETCHQ;
            end
         end
         S_FETCHQ: begin
            ins_in   = mem_q;
            pc_in    = pc_ff + 32'd1;
            rf_ra    = mem_q[26:24];
            state_in = S_RB;
         end
         S_RB: begin
            v1_in    = rf_val;
            rf_ra    = n2[2:0];
            state_in = S_RC;
         end
         S_RC: begin
            v2_in    = rf_val;
            rf_ra    = n3[2:0];
            state_in = S_RD;
         end
         S_RD: begin
            v3_in    = rf_val;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            wb_in    = 1'b0;
            mret_in  = 1'b0;
            mwr_in   = 1'b0;
            state_in = S_IRQA;
            case (op)
               OP_SYS: begin
                  if (ins_ff == 32'd0) begin
                     halt_in = 1'b1;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
               OP_ROT: begin
                  if (n3_const) begin
                     cf_in    = 1'b1;
                     halt_in  = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     wb_in    = 1'b1;
                     state_in = S_WB;
                     case (op)
                        OP_ADD: r_in = a1 + a2;
                        OP_SUB: r_in = a1 - a2;
                        OP_MUL: r_in = a1 * a2;
                        OP_AND: r_in = a1 & a2;
                        OP_OR:  r_in = a1 | a2;
                        OP_XOR: r_in = a1 ^ a2;
                        OP_ROT: r_in = rot[63:32];
                        default: begin
                           if (a2 == 32'd0) begin
                              r_in   = 32'd0;
                              bad_in = 1'b1;
                           end else begin
                              div_start = 1'b1;
                              state_in  = S_DIV;
                           end
                        end
                     endcase
                  end
               end
               OP_MISC: begin
                  case (n1)
                     SUB_NEG, SUB_NOT, SUB_MOVE: begin
                        if (n3_const) begin
                           cf_in    = 1'b1;
                           halt_in  = 1'b1;
                           state_in = S_DONE;
                        end else begin
                           r_in     = (n1 == SUB_NEG) ? (32'd0 - a2) :
                                      ((n1 == SUB_NOT) ? ~a2 : a2);
                           wb_in    = 1'b1;
                           state_in = S_WB;
                        end
                     end
                     SUB_CALL: begin
                        if (n3 == CALL_CALL) begin
                           sp_in    = sp_inc;
                           maddr_in = sp_inc;
                           mdata_in = pc_ff;
                           mwr_in   = 1'b1;
                           pc_in    = imm;
                           state_in = S_MEM;
                        end else if (n3 == CALL_RET) begin
                           sp_in    = sp_ff - 32'd1;
                           maddr_in = sp_ff;
                           mret_in  = 1'b1;
                           state_in = S_MEM;
                        end else if (n3 == CALL_TRAP) begin
                           pend_in[2] = 1'b1;
                        end else begin
                           bad_in = 1'b1;
                        end
                     end
                     SUB_JUMP: begin
                        case (n2)
                           JMP_ALWAYS: pc_in = imm;
                           JMP_ZERO:   if (g3 == 32'd0) pc_in = imm;
                           JMP_NEG:    if (g3[31]) pc_in = imm;
                           JMP_NZERO:  if (g3 != 32'd0) pc_in = imm;
                           default:    bad_in = 1'b1;
                        endcase
                     end
                     SUB_SR: begin
                        if (n2 == MODE_CLEAR) begin
                           sr_in = sr_ff & ~(32'd1 << n3);
                        end else if (n2 == MODE_SET) begin
                           sr_in = sr_ff | (32'd1 << n3);
                        end else begin
                           bad_in = 1'b1;
                        end
                     end
                     SUB_STACK: begin
                        if (n2 == MODE_CLEAR) begin
                           sp_in    = sp_inc;
                           maddr_in = sp_inc;
                           mdata_in = a3;
                           mwr_in   = 1'b1;
                           state_in = S_MEM;
                        end else if (n2 == MODE_SET) begin
                           if (n3_const) begin
                              cf_in    = 1'b1;
                              halt_in  = 1'b1;
                              state_in = S_DONE;
                           end else begin
                              sp_in    = sp_ff - 32'd1;
                              maddr_in = sp_ff;
                              wb_in    = 1'b1;
                              state_in = S_MEM;
                           end
                        end else begin
                           bad_in = 1'b1;
                        end
                     end
                     default: bad_in = 1'b1;
                  endcase
               end
               OP_LOAD: begin
                  if (n1 > LD_BASE) begin
                     bad_in = 1'b1;
                  end else if (n3_const) begin
                     cf_in    = 1'b1;
                     halt_in  = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     wb_in = 1'b1;
                     case (n1)
                        LD_IMM: begin
                           r_in     = sext;
                           state_in = S_WB;
                        end
                        LD_ABS: begin
                           maddr_in = imm;
                           state_in = S_MEM;
                        end
                        LD_IND: begin
                           maddr_in = g2;
                           state_in = S_MEM;
                        end
                        default: begin
                           maddr_in = g2 + sext;
                           state_in = S_MEM;
                        end
                     endcase
                  end
               end
               OP_STORE: begin
                  mdata_in = g2;
                  mwr_in   = 1'b1;
                  case (n1)
                     LD_ABS: begin
                        maddr_in = imm;
                        state_in = S_MEM;
                     end
                     LD_IND: begin
                        maddr_in = g3;
                        state_in = S_MEM;
                     end
                     LD_BASE: begin
                        maddr_in = g3 + sext;
                        state_in = S_MEM;
                     end
                     default: bad_in = 1'b1;
                  endcase
               end
               default: bad_in = 1'b1;
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               r_in     = div_res;
               state_in = S_WB;
            end
         end
         S_MEM: begin
            mem_a  = maddr_ff;
            inr_in = maddr_ff < MEM_LIM;
            mem_we = mwr_ff && (maddr_ff < MEM_LIM);
            if (maddr_ff >= MEM_LIM) begin
               pend_in[0] = 1'b1;
            end
            state_in = mwr_ff ? S_IRQA : S_MEMQ;
         end
         S_MEMQ: begin
            r_in = inr_ff ? mem_q : 32'd0;
            if (mret_ff) begin
               pc_in = inr_ff ? mem_q : 32'd0;
            end
            state_in = S_WB;
         end
         S_WB: begin
            if (wb_ff) begin
               if (n3 == N_SP) begin
                  sp_in = r_ff;
               end else if (n3 == N_SR) begin
                  sr_in = r_ff;
               end else if (n3 == N_PC) begin
                  pc_in = r_ff;
               end else begin
                  rf_we = 1'b1;
               end
            end
            state_in = S_IRQA;
         end
         S_IRQA: begin
            if (sr_ff[2]) begin
               tc_in   = (tc_inc >= period_ff) ? 16'd0 : tc_inc;
               fire_in = (tc_inc >= period_ff) || (tc_inc == 16'd0);
            end else begin
               tc_in   = 16'd0;
               fire_in = 1'b0;
            end
            mem_a    = KBD_CTRL_ADDR;
            state_in = S_IRQB;
         end
         S_IRQB: begin
            mem_a  = sp_inc;
            mem_wd = pc_ff;
            irq_in = IRQ_NONE;
            if (pend_ff[0]) begin
               pend_in[0] = 1'b0;
               irq_in     = IRQ_FAULT;
            end else if (pend_ff[1] && CTRL_OK && mem_q == 32'd1) begin
               pend_in[1] = 1'b0;
               irq_in     = IRQ_KEY;
            end else if (pend_ff[2]) begin
               pend_in[2] = 1'b0;
               irq_in     = IRQ_TRAP;
            end else if (fire_ff) begin
               irq_in = IRQ_TIMER;
            end
            if (irq_in != IRQ_NONE) begin
               // A failed push of the return address raises no new fault.
               mem_we = sp_inc < MEM_LIM;
               sp_in  = sp_inc;
               pc_in  = {29'd0, irq_in - 3'd1};
               sr_in  = sr_ff | 32'd2;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = rd_ff;
               rsp_pc_in    = pc_ff[15:0];
               rsp_halt_in  = halt_ff;
               rsp_bad_in   = bad_ff;
               rsp_cf_in    = cf_ff;
               rsp_irq_in   = irq_ff;
               rsp_sr_in    = sr_ff[2:0];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      act_in_hold: begin
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      haddr_ff  <= haddr_in;
      hdata_ff  <= hdata_in;
      key_ff    <= key_in;
      ins_ff    <= ins_in;
      v1_ff     <= v1_in;
      v2_ff     <= v2_in;
      v3_ff     <= v3_in;
      r_ff      <= r_in;
      wb_ff     <= wb_in;
      maddr_ff  <= maddr_in;
      mdata_ff  <= mdata_in;
      mwr_ff    <= mwr_in;
      mret_ff   <= mret_in;
      inr_ff    <= inr_in;
      fire_ff   <= fire_in;
      bad_ff    <= bad_in;
      cf_ff     <= cf_in;
      irq_ff    <= irq_in;
      rd_ff     <= rd_in;
      rsp_rd_ff   <= rsp_rd_in;
      rsp_pc_ff   <= rsp_pc_in;
      rsp_halt_ff <= rsp_halt_in;
      rsp_bad_ff  <= rsp_bad_in;
      rsp_cf_ff   <= rsp_cf_in;
      rsp_irq_ff  <= rsp_irq_in;
      rsp_sr_ff   <= rsp_sr_in;
      rf_qv_ff    <= rf_vld_ff[rf_ra];
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= SP_RESET;
         sr_ff        <= 32'd0;
         pc_ff        <= PC_RESET;
         tc_ff        <= 16'd0;
         period_ff    <= PERIOD_RESET;
         pend_ff      <= 3'd0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rf_vld_ff    <= 8'd0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         sr_ff        <= sr_in;
         pc_ff        <= pc_in;
         tc_ff        <= tc_in;
         period_ff    <= period_in;
         pend_ff      <= pend_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rf_we) begin
            rf_vld_ff[rf_wa] <= 1'b1;
         end
      end
   end

   assign req_stall                = state_ff != S_IDLE;
   assign csr_ready                = 1'b1;
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_read_data            = $signed(rsp_rd_ff);
   assign rsp_pc_after             = rsp_pc_ff;
   assign rsp_halted               = rsp_halt_ff;
   assign rsp_invalid_instruction  = rsp_bad_ff;
   assign rsp_constant_write_fault = rsp_cf_ff;
   assign rsp_interrupt_taken      = rsp_irq_ff;
   assign rsp_status_bits          = rsp_sr_ff;

endmodule
`default_nettype wire

// File: src/tcc_chk.sv
`default_nettype none
module tcc_chk
   import tcc_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic [1:0]         req_action,
   input wire logic [15:0]        req_address,
   input wire logic signed [31:0] req_data,
   input wire logic               req_key_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [31:0] rsp_read_data,
   input wire logic [15:0]        rsp_pc_after,
   input wire logic               rsp_halted,
   input wire logic               rsp_invalid_instruction,
   input wire logic               rsp_constant_write_fault,
   input wire logic [2:0]         rsp_interrupt_taken,
   input wire logic [2:0]         rsp_status_bits,
   input wire logic               csr_valid,
   input wire logic               csr_ready,
   input wire logic [15:0]        csr_timer_period
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pc_after)
                                 && $stable(rsp_read_data))
      else $error("stalled result changed");

   // A constant register target always halts the core.
   a_cf_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_constant_write_fault |-> rsp_halted
                                                && rsp_interrupt_taken == IRQ_NONE)
      else $error("constant write fault without halt");

   // Interrupt codes stay in their range, and a taken one sets status bit 1, masking keyboard interrupts.
   a_irq_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_interrupt_taken != IRQ_NONE |-> rsp_interrupt_taken <= IRQ_TIMER
                                                      && rsp_status_bits[1])
      else $error("bad interrupt report");

   // Read data appears only for a host read, which reports no execution flags.
   a_rd_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_data != 0 |-> !rsp_invalid_instruction
                                          && !rsp_constant_write_fault
                                          && rsp_interrupt_taken == IRQ_NONE)
      else $error("read data with execution flags");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind teaching_cpu_core_step tcc_chk u_tcc_chk (.*);
`default_nettype wire
